>>> hw/rtl/framebuffer_text_renderer_top_defines.svh
// Assertion macros shared by the framebuffer renderer checker.
// No dependencies.
`ifndef FRAMEBUFFER_TEXT_RENDERER_TOP_DEFINES_SVH
`define FRAMEBUFFER_TEXT_RENDERER_TOP_DEFINES_SVH
// implication checked on every edge outside reset
`define FTR_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("lbl failed");
// next-cycle implication
`define FTR_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("lbl failed");
`endif

>>> hw/rtl/ftr_pkg.sv
// Shared types and codes for the framebuffer text renderer.
// No dependencies.
package ftr_pkg;
  localparam logic [2:0] REQ_PIXEL  = 3'd0;
  localparam logic [2:0] REQ_FILL   = 3'd1;
  localparam logic [2:0] REQ_CURSOR = 3'd2;
  localparam logic [2:0] REQ_CHAR   = 3'd3;
  localparam logic [2:0] REQ_FONT   = 3'd4;
  localparam logic [2:0] REQ_READ   = 3'd5;
  localparam logic [1:0] CFG_INVERT = 2'd0;
  localparam logic [1:0] CFG_FWIDTH = 2'd1;
  localparam logic [1:0] CFG_FHEIGHT = 2'd2;
  localparam logic [7:0] FIRST_CODE = 8'd32;
  localparam logic [7:0] LAST_CODE  = 8'd127;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic        pixel_color;
    logic [7:0]  char_code;
    logic [10:0] font_address;
    logic [15:0] font_word;
    logic [9:0]  frame_address;
    logic        reject;
  } cmd_t;

  typedef struct packed {
    logic       status;
    logic [7:0] read_byte;
    logic [7:0] char_echo;
  } result_t;
endpackage

>>> hw/rtl/ftr_front.sv
// Front end: accepts requests, checks codes and buffers them in a short queue.
// Depends on ftr_pkg.
module ftr_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ftr_pkg::cmd_t in_cmd,
  output logic          q_valid,
  input  logic          q_ready,
  output ftr_pkg::cmd_t q_cmd
);
  import ftr_pkg::*;
  cmd_t        slot_r [2];
  logic [1:0]  cnt_r, cnt_nxt;
  logic        wp_r, rp_r;
  logic        push, pop;
  cmd_t        c;

  always_comb begin
    c = in_cmd;
    c.reject = (in_cmd.req_type > REQ_READ);
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_cmd = slot_r[rp_r];
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= c;
  end
endmodule

>>> hw/rtl/ftr_back.sv
// Back end: executes requests against frame and font memories.
// Depends on ftr_pkg.
module ftr_back #(
  parameter int SCREEN_W = 128,
  parameter int SCREEN_H = 64,
  parameter int MAX_FONT_H = 18,
  parameter int GLYPH_COUNT = 96
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  ftr_pkg::cmd_t    cmd,
  input  logic             invert,
  input  logic [4:0]       font_w,
  input  logic [4:0]       font_h,
  output logic             res_valid,
  input  logic             res_ready,
  output ftr_pkg::result_t res
);
  import ftr_pkg::*;
  localparam int FRAME_BYTES = SCREEN_W * ((SCREEN_H + 7) / 8);
  localparam int FONT_WORDS = GLYPH_COUNT * MAX_FONT_H;
  localparam int FAW = $clog2(FRAME_BYTES);
  localparam int GAW = $clog2(FONT_WORDS);

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_FILL, S_PX_RD, S_PX_WR, S_RD_WAIT, S_RD_DATA,
    S_CH_ROW, S_CH_WAIT, S_CH_COL, S_CH_WB, S_DONE
  } state_t;

  logic [7:0]  frame_mem [FRAME_BYTES];
  logic [15:0] font_mem [FONT_WORDS];
  logic [7:0]  frd_r;
  logic [15:0] grd_r;

  state_t      state_r;
  cmd_t        cur_r;
  logic [FAW:0] sweep_r;
  logic        fill_val_r;
  logic [7:0]  cx_r, cy_r;
  logic [4:0]  row_r, col_r;
  logic [15:0] bits_r;
  logic [8:0]  px_r, py_r;
  logic        color_r;
  logic        res_valid_r;
  result_t     res_r;

  // frame and font port requests
  logic        fwe;
  logic [FAW-1:0] faddr;
  logic [7:0]  fwdata;
  logic        gwe;
  logic [GAW-1:0] gaddr;

  logic [8:0]  sum_x, sum_y;
  logic [15:0] widx;
  logic        pix_on, pix_col, in_scr;
  logic [FAW+8:0] pidx;
  logic [7:0]  bitmask;
  logic        cur_color;

  // decode of the request taken in idle
  state_t      idle_state;
  logic        idle_status;
  logic [7:0]  idle_echo;
  logic        idle_adv;

  assign cmd_ready = (state_r == S_IDLE) && !res_valid_r;
  assign res_valid = res_valid_r;
  assign res = res_r;

  assign sum_x = {1'b0, cx_r} + {4'd0, font_w};
  assign sum_y = {1'b0, cy_r} + {4'd0, font_h};
  assign widx = 16'(({8'd0, cur_r.char_code} - 16'(FIRST_CODE)) * {11'd0, font_h})
              + {11'd0, row_r};
  assign in_scr = (32'(px_r) < SCREEN_W) && (32'(py_r) < SCREEN_H);
  assign pidx = (FAW+9)'(px_r) + (FAW+9)'((py_r >> 3) * SCREEN_W);
  assign bitmask = 8'd1 << py_r[2:0];
  assign pix_on = (col_r < 5'd16) && bits_r[15];
  assign pix_col = color_r ^ invert;
  assign cur_color = pix_on ? pix_col : ~pix_col;

  always_comb begin
    idle_state = S_DONE;
    idle_status = 1'b0;
    idle_echo = '0;
    idle_adv = 1'b0;
    if (cmd.reject) idle_status = 1'b1;
    else begin
      unique case (cmd.req_type)
        REQ_PIXEL: begin
          if ({1'b0, cmd.pos_x} >= 9'(SCREEN_W) ||
              {1'b0, cmd.pos_y} >= 9'(SCREEN_H)) idle_status = 1'b1;
          else idle_state = S_PX_RD;
        end
        REQ_FILL: idle_state = S_FILL;
        REQ_CURSOR: ;
        REQ_CHAR: begin
          if (cmd.char_code < FIRST_CODE || cmd.char_code > LAST_CODE ||
              32'(sum_x) >= SCREEN_W || 32'(sum_y) >= SCREEN_H)
            idle_status = 1'b1;
          else if (font_h == 5'd0 || font_w == 5'd0) begin
            idle_echo = cmd.char_code;
            idle_adv = 1'b1;
          end else idle_state = S_CH_ROW;
        end
        REQ_FONT: if (32'(cmd.font_address) >= FONT_WORDS) idle_status = 1'b1;
        REQ_READ: begin
          if (32'(cmd.frame_address) >= FRAME_BYTES) idle_status = 1'b1;
          else idle_state = S_RD_WAIT;
        end
        default: idle_status = 1'b1;
      endcase
    end
  end

  always_comb begin
    fwe = 1'b0;
    faddr = '0;
    fwdata = '0;
    gwe = 1'b0;
    gaddr = '0;
    unique case (state_r)
      S_CLEAR, S_FILL: begin
        fwe = 1'b1;
        faddr = sweep_r[FAW-1:0];
        fwdata = {8{fill_val_r}};
      end
      S_PX_RD, S_CH_COL: faddr = pidx[FAW-1:0];
      S_PX_WR, S_CH_WB: begin
        fwe = in_scr && (32'(pidx) < FRAME_BYTES);
        faddr = pidx[FAW-1:0];
        fwdata = (state_r == S_PX_WR ? (pix_col) : cur_color) ?
                 (frd_r | bitmask) : (frd_r & ~bitmask);
      end
      S_RD_WAIT: faddr = FAW'(cur_r.frame_address);
      S_CH_ROW: gaddr = widx[GAW-1:0];
      default: ;
    endcase
    if (state_r == S_IDLE && cmd_valid && !res_valid_r && !cmd.reject &&
        cmd.req_type == REQ_FONT && 32'(cmd.font_address) < FONT_WORDS) begin
      gwe = 1'b1;
      gaddr = GAW'(cmd.font_address);
    end
  end

  always_ff @(posedge clk) begin
    if (fwe) frame_mem[faddr] <= fwdata;
    frd_r <= frame_mem[faddr];
    if (gwe) font_mem[gaddr] <= cmd.font_word;
    grd_r <= font_mem[gaddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      sweep_r <= '0;
      fill_val_r <= 1'b0;
      cx_r <= '0;
      cy_r <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (res_valid_r && res_ready) res_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR, S_FILL: begin
          if (32'(sweep_r) == FRAME_BYTES - 1) begin
            if (state_r == S_CLEAR) state_r <= S_IDLE;
            else state_r <= S_DONE;
          end
          sweep_r <= sweep_r + 1'b1;
        end
        S_IDLE: if (cmd_valid && !res_valid_r) begin
          cur_r <= cmd;
          res_r <= {idle_status, 8'd0, idle_echo};
          px_r <= {1'b0, cmd.pos_x};
          py_r <= {1'b0, cmd.pos_y};
          color_r <= cmd.pixel_color;
          row_r <= '0;
          sweep_r <= '0;
          fill_val_r <= cmd.pixel_color;
          state_r <= idle_state;
          if (!cmd.reject && cmd.req_type == REQ_CURSOR) begin
            cx_r <= cmd.pos_x;
            cy_r <= cmd.pos_y;
          end else if (idle_adv) cx_r <= sum_x[7:0];
        end
        S_PX_RD: state_r <= S_PX_WR;
        S_PX_WR: state_r <= S_DONE;
        S_RD_WAIT: state_r <= S_RD_DATA;
        S_RD_DATA: begin
          res_r.read_byte <= frd_r;
          state_r <= S_DONE;
        end
        S_CH_ROW: state_r <= S_CH_WAIT;
        S_CH_WAIT: begin
          bits_r <= (32'(widx) < FONT_WORDS) ? grd_r : 16'd0;
          col_r <= '0;
          px_r <= {1'b0, cx_r};
          py_r <= {1'b0, cy_r} + {4'd0, row_r};
          state_r <= S_CH_COL;
        end
        S_CH_COL: state_r <= S_CH_WB;
        S_CH_WB: begin
          bits_r <= {bits_r[14:0], 1'b0};
          col_r <= col_r + 5'd1;
          px_r <= px_r + 9'd1;
          if (col_r + 5'd1 >= font_w) begin
            row_r <= row_r + 5'd1;
            if (row_r + 5'd1 >= font_h) begin
              res_r.char_echo <= cur_r.char_code;
              cx_r <= sum_x[7:0];
              state_r <= S_DONE;
            end else state_r <= S_CH_ROW;
          end else state_r <= S_CH_COL;
        end
        S_DONE: begin
          res_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hw/rtl/framebuffer_text_renderer_top.sv
// Framebuffer text renderer, top level: config registers, front queue, back end.
// One request at a time in the back end. Reset: synchronous rst_n; afterwards the
// frame memory is cleared (all FRAME_BYTES bytes, 1024 by default) before the back
// end takes a request; the front queue holds up to two requests meanwhile.
module framebuffer_text_renderer_top #(
  parameter int SCREEN_W = 128,
  parameter int SCREEN_H = 64,
  parameter int MAX_FONT_H = 18,
  parameter int GLYPH_COUNT = 96
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // req_type[2:0]
  input  logic [2:0]  in_tuser,
  // pos_x, pos_y, pixel_color, char_code, font_address[10:0],
  // font_word[15:0], frame_address[9:0], zero pad
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status, read_byte[7:0], char_echo[7:0], zero pad
  output logic [23:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);
  import ftr_pkg::*;
  logic       inv_r;
  logic [4:0] fw_r, fh_r;
  cmd_t       in_cmd, q_cmd;
  logic       q_valid, q_ready;
  result_t    res;

  always_comb begin
    in_cmd.req_type = in_tuser;
    in_cmd.pos_x = in_tdata[7:0];
    in_cmd.pos_y = in_tdata[15:8];
    in_cmd.pixel_color = in_tdata[16];
    in_cmd.char_code = in_tdata[24:17];
    in_cmd.font_address = in_tdata[35:25];
    in_cmd.font_word = in_tdata[51:36];
    in_cmd.frame_address = in_tdata[61:52];
    in_cmd.reject = 1'b0;
  end

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
      fw_r <= 5'd7;
      fh_r <= 5'd10;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_INVERT:  inv_r <= cfg_data[0];
        CFG_FWIDTH:  fw_r <= cfg_data;
        CFG_FHEIGHT: fh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ftr_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_cmd,
    .q_valid, .q_ready, .q_cmd
  );

  ftr_back #(
    .SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H),
    .MAX_FONT_H(MAX_FONT_H), .GLYPH_COUNT(GLYPH_COUNT)
  ) u_back (
    .clk, .rst_n, .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .invert(inv_r), .font_w(fw_r), .font_h(fh_r),
    .res_valid(out_tvalid), .res_ready(out_tready), .res
  );

  assign out_tdata = {7'd0, res.char_echo, res.read_byte, res.status};
endmodule

>>> hw/rtl/ftr_checker.sv
// Port-level checker for the framebuffer text renderer, bound to the top.
// Depends on framebuffer_text_renderer_top_defines.svh.
`include "framebuffer_text_renderer_top_defines.svh"
module ftr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);
  // a result with status set never carries an echoed character
  `FTR_ASSERT_IMP(a_rej_no_echo, out_tvalid && out_tdata[0], out_tdata[16:9] == 8'd0)
  // a read byte and an echoed character never appear together
  `FTR_ASSERT_IMP(a_excl, out_tvalid && out_tdata[8:1] != 8'd0, out_tdata[16:9] == 8'd0)
  // a stalled result holds
  `FTR_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule

bind framebuffer_text_renderer_top ftr_checker u_ftr_checker (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata
);
